>>> design/tcw_pkg.sv
// Package for the text console writer: command and result payload types,
// command and register codes, and fixed character and reset constants. No dependencies.
package tcw_pkg;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [7:0]  char_code;
		logic [12:0] position;
	} tcw_in_t;

	typedef struct packed {
		logic [12:0] cursor_pos;
		logic [7:0]  cell_char;
		logic [7:0]  cell_attr;
	} tcw_out_t;

	localparam logic [1:0] CMD_PUT   = 2'd0;
	localparam logic [1:0] CMD_CLEAR = 2'd1;
	localparam logic [1:0] CMD_MOVE  = 2'd2;
	localparam logic [1:0] CMD_READ  = 2'd3;

	localparam logic [1:0] REG_ATTRIBUTE = 2'd0;
	localparam logic [1:0] REG_COLUMNS   = 2'd1;
	localparam logic [1:0] REG_ROWS      = 2'd2;

	localparam logic [7:0] NEWLINE_CODE = 8'h0A;
	localparam logic [7:0] BLANK_CODE   = 8'h20;
	localparam logic [7:0] RESET_ATTR   = 8'h07;
	localparam logic [7:0] RESET_COLS   = 8'd80;
	localparam logic [6:0] RESET_ROWS   = 7'd25;

endpackage

>>> design/text_console_writer.sv
// Text console writer: screen cell store, cursor, scroll and clear sequencer.
// Depends on tcw_pkg.
// Commands: put (a newline moves to the next row start), clear, move and read.
// Rows are trimmed one at a time while columns*rows exceeds CELLS. A scroll or a
// clear rewrites the screen one cell a cycle through the single memory write port.
// One command at a time; busy is high until the result.
// After reset a clearing pass fills the store (busy high).
// The result strobe done lasts one cycle and cannot be stalled.
module text_console_writer #(
	parameter int CELLS = 8192
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  tcw_pkg::tcw_in_t  item,
	output logic              done,
	output tcw_pkg::tcw_out_t result,
	input  logic              wr_en,
	input  logic [1:0]        wr_index,
	input  logic [7:0]        wr_data
);
	import tcw_pkg::*;

	localparam int AW = $clog2(CELLS);
	localparam int CW = AW + 1;
	localparam int XW = (CW > 13) ? CW : 13;
	localparam int TW = XW + 1;
	localparam int BW = $clog2(AW);
	localparam int PW = 15;
	localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
	localparam logic [15:0] RESET_WORD = {RESET_ATTR, BLANK_CODE};

	typedef enum logic [3:0] {
		ST_INIT, ST_IDLE, ST_GEOM, ST_DIV, ST_CHECK,
		ST_WALK, ST_DRAIN, ST_READ, ST_FINISH
	} state_t;

	state_t state_q;

	logic [7:0]    attr_q, cols_q;
	logic [6:0]    rows_q;
	logic [1:0]    cmd_q;
	logic [7:0]    char_q;
	logic [12:0]   pos_q;
	logic [7:0]    ec_q;
	logic [6:0]    er_q;
	logic [CW-1:0] total_q, last_q, lim_q;
	logic [AW-1:0] cur_q, idx_q;
	logic [TW-1:0] target_q;
	logic [7:0]    rem_q;
	logic [BW-1:0] bit_q;
	logic          wr_vld_s1, wr_copy_s1;
	logic [AW-1:0] wr_addr_s1;
	logic [15:0]   rdata_q;
	logic [15:0]   mem [CELLS];

	logic [7:0]    cols_nz, ec_in;
	logic [6:0]    er_in;
	logic [PW-1:0] prod;
	logic          geom_ok;
	logic [8:0]    r9, r9_sub;
	logic [7:0]    rem_n;
	logic [CW-1:0] tot_m1, rd_sum;
	logic          copy;
	logic [XW-1:0] pos_ext;
	logic          pos_in;
	logic [TW-1:0] cur_ext;
	logic          mem_we, rd_en;
	logic [AW-1:0] mem_waddr, rd_addr;
	logic [15:0]   mem_wdata;

	assign busy = (state_q != ST_IDLE);

	// Effective geometry: zero counts as one, columns limited to the store.
	assign cols_nz = (cols_q == 8'd0) ? 8'd1 : cols_q;
	assign ec_in   = (16'(cols_nz) > 16'(CELLS)) ? 8'(CELLS) : cols_nz;
	assign er_in   = (rows_q == 7'd0) ? 7'd1 : rows_q;
	assign prod    = PW'(ec_q) * PW'(er_q);
	assign geom_ok = (prod <= PW'(CELLS));

	// One restoring step of cursor modulo columns.
	assign r9     = {rem_q, cur_q[bit_q]};
	assign r9_sub = r9 - {1'b0, ec_q};
	assign rem_n  = (r9 >= {1'b0, ec_q}) ? r9_sub[7:0] : r9[7:0];

	assign tot_m1  = total_q - CW'(1);
	assign copy    = ({1'b0, idx_q} < lim_q);
	assign rd_sum  = {1'b0, idx_q} + CW'(ec_q);
	assign pos_ext = XW'(pos_q);
	assign pos_in  = (pos_ext < XW'(CELLS));
	assign cur_ext = TW'(cur_q);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = RESET_WORD;
		if (wr_vld_s1) begin
			mem_we    = 1'b1;
			mem_waddr = wr_addr_s1;
			mem_wdata = wr_copy_s1 ? rdata_q : {attr_q, BLANK_CODE};
		end else begin
			case (state_q)
				ST_INIT: begin
					mem_we = 1'b1;
				end
				ST_GEOM: begin
					if (geom_ok && cmd_q == CMD_PUT && char_q != NEWLINE_CODE) begin
						mem_we    = 1'b1;
						mem_waddr = cur_q;
						mem_wdata = {attr_q, char_q};
					end
				end
				default: begin
					mem_we = 1'b0;
				end
			endcase
		end
	end

	always_comb begin
		if (state_q == ST_WALK) begin
			rd_en   = copy;
			rd_addr = rd_sum[AW-1:0];
		end else begin
			rd_en   = (state_q == ST_GEOM) && geom_ok && (cmd_q == CMD_READ) && pos_in;
			rd_addr = pos_ext[AW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= RESET_ATTR;
			cols_q <= RESET_COLS;
			rows_q <= RESET_ROWS;
		end else if (wr_en) begin
			case (wr_index)
				REG_ATTRIBUTE: attr_q <= wr_data;
				REG_COLUMNS:   cols_q <= wr_data;
				REG_ROWS:      rows_q <= wr_data[6:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_INIT;
			idx_q      <= '0;
			cur_q      <= '0;
			done       <= 1'b0;
			result     <= '0;
			wr_vld_s1  <= 1'b0;
			wr_copy_s1 <= 1'b0;
			wr_addr_s1 <= '0;
			cmd_q      <= CMD_PUT;
			char_q     <= '0;
			pos_q      <= '0;
			ec_q       <= 8'd1;
			er_q       <= 7'd1;
			total_q    <= '0;
			last_q     <= '0;
			lim_q      <= '0;
			target_q   <= '0;
			rem_q      <= '0;
			bit_q      <= '0;
		end else begin
			done      <= 1'b0;
			wr_vld_s1 <= 1'b0;
			case (state_q)
				ST_INIT: begin
					idx_q <= idx_q + AW'(1);
					if (idx_q == LAST_CELL) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						cmd_q   <= item.cmd;
						char_q  <= item.char_code;
						pos_q   <= item.position;
						ec_q    <= ec_in;
						er_q    <= er_in;
						state_q <= ST_GEOM;
					end
				end
				ST_GEOM: begin
					// Trim rows one at a time until the screen fits the store.
					if (!geom_ok) begin
						er_q <= er_q - 7'd1;
					end else begin
						total_q <= CW'(prod);
						last_q  <= CW'(prod - PW'(ec_q));
						case (cmd_q)
							CMD_PUT: begin
								if (char_q == NEWLINE_CODE) begin
									rem_q   <= '0;
									bit_q   <= BW'(AW - 1);
									state_q <= ST_DIV;
								end else begin
									target_q <= cur_ext + TW'(1);
									state_q  <= ST_CHECK;
								end
							end
							CMD_CLEAR: begin
								cur_q   <= '0;
								lim_q   <= '0;
								idx_q   <= '0;
								state_q <= ST_WALK;
							end
							CMD_MOVE: begin
								target_q <= TW'(pos_q);
								state_q  <= ST_CHECK;
							end
							default: begin
								state_q <= ST_READ;
							end
						endcase
					end
				end
				ST_DIV: begin
					rem_q <= rem_n;
					if (bit_q == '0) begin
						target_q <= cur_ext + TW'(ec_q) - TW'(rem_n);
						state_q  <= ST_CHECK;
					end else begin
						bit_q <= bit_q - BW'(1);
					end
				end
				ST_CHECK: begin
					if (target_q >= TW'(total_q)) begin
						cur_q   <= last_q[AW-1:0];
						lim_q   <= last_q;
						idx_q   <= '0;
						state_q <= ST_WALK;
					end else begin
						cur_q   <= target_q[AW-1:0];
						state_q <= ST_FINISH;
					end
				end
				ST_WALK: begin
					// Cells below the limit take the cell one row down; the rest are blanked.
					wr_vld_s1  <= 1'b1;
					wr_addr_s1 <= idx_q;
					wr_copy_s1 <= copy;
					idx_q      <= idx_q + AW'(1);
					if (idx_q == tot_m1[AW-1:0]) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FINISH;
				end
				ST_READ: begin
					done              <= 1'b1;
					result.cursor_pos <= cur_ext[12:0];
					result.cell_char  <= pos_in ? rdata_q[7:0] : 8'd0;
					result.cell_attr  <= pos_in ? rdata_q[15:8] : 8'd0;
					state_q           <= ST_IDLE;
				end
				ST_FINISH: begin
					done              <= 1'b1;
					result.cursor_pos <= cur_ext[12:0];
					result.cell_char  <= 8'd0;
					result.cell_attr  <= 8'd0;
					state_q           <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> design/tcw_checker.sv
// Port-level checker for the text console writer and its bind statement.
// Depends only on the top level's handshake ports.
module tcw_port_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);

	// A result never shows while a command is still being worked on.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result strobe while busy");

	// An accepted command makes the block busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("not busy after a transfer in");

	// Every result ends a period of work.
	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("result without preceding work");

	// One result per command: strobes never come back to back.
	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("repeated result strobe");

endmodule

bind text_console_writer tcw_port_checker u_tcw_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);
